>>> rtl/core/bcs_pkg.sv
// shared types and constants for the bezier connector segmenter
// no dependencies; every module of the block imports this package
package bcs_pkg;

    localparam int SEGMENTS_DEF = 20;

    // fixed-point layout: t in Q1.16, curve sums scaled by 2^48
    localparam int FRAC  = 48;
    localparam int SW    = 67;
    localparam int GW    = 49;
    localparam int FW    = 48;
    localparam int SPLIT = 24;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } pts_t;

    typedef struct packed {
        logic signed [15:0] seg_x0;
        logic signed [15:0] seg_y0;
        logic signed [15:0] seg_x1;
        logic signed [15:0] seg_y1;
        logic               last_segment;
    } seg_t;

    // one curve evaluation as issued by the sequencer
    typedef struct packed {
        logic signed [15:0]   sx;
        logic signed [15:0]   sy;
        logic signed [16:0]   dx;
        logic signed [15:0]   hx;
        logic signed [16:0]   dy;
        logic        [GW-1:0] g;
        logic signed [FW-1:0] f;
        logic                 first;
        logic                 last;
    } eval_t;

    // partial products
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [41:0] xg_lo;
        logic signed [42:0] xg_hi;
        logic signed [40:0] xf_lo;
        logic signed [39:0] xf_hi;
        logic signed [41:0] yg_lo;
        logic signed [42:0] yg_hi;
        logic               first;
        logic               last;
    } prod_t;

    // recombined products
    typedef struct packed {
        logic signed [15:0]   sx;
        logic signed [15:0]   sy;
        logic signed [SW-1:0] xg;
        logic signed [SW-1:0] xf;
        logic signed [SW-1:0] yg;
        logic                 first;
        logic                 last;
    } acc_t;

    // full curve sums, point = sum / 2^48
    typedef struct packed {
        logic signed [15:0]   sx;
        logic signed [15:0]   sy;
        logic signed [SW-1:0] px;
        logic signed [SW-1:0] py;
        logic                 first;
        logic                 last;
    } sum_t;

endpackage

>>> rtl/core/bezier_connector_segments.sv
// top level of the cubic bezier connector segmenter
// depends on bcs_pkg, bcs_seq, bcs_mul, bcs_sum, bcs_out

// Each beat on pts gives the start and end of a connector; the block answers
// with SEGMENTS beats on seg (20 by default), the straight pieces of a cubic
// Bezier whose inner control points sit half way across in x at the start
// and end heights. The sequencer issues one curve evaluation per cycle while
// the multiply stage can take it, and a new connector is taken in the cycle
// its predecessor's last evaluation goes out; with seg_ready held high the
// output stream has no gaps between connectors. The first segment of each
// connector passes the sequencer, multiply, add and output registers. Curve
// points are exact sums of weight times span, scaled by 2^48 and truncated
// toward zero; the weights for each step are constant tables built from
// SEGMENTS at elaboration. Backpressure on seg freezes the stages behind it
// without dropping or repeating anything.
module bezier_connector_segments #(
    parameter int SEGMENTS = bcs_pkg::SEGMENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pts_valid,
    output logic          pts_ready,
    input  bcs_pkg::pts_t pts,
    output logic          seg_valid,
    input  logic          seg_ready,
    output bcs_pkg::seg_t seg
);
    import bcs_pkg::*;

    // stage links
    logic  ev_valid, ev_ready;
    eval_t ev;
    logic  pr_valid, pr_ready;
    prod_t pr;
    logic  sm_valid, sm_ready;
    sum_t  sm;

    // step counter and weight lookup
    bcs_seq #(
        .SEGMENTS (SEGMENTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .pts_valid (pts_valid),
        .pts_ready (pts_ready),
        .pts       (pts),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev        (ev)
    );

    // six narrow multipliers, one register stage
    bcs_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev),
        .pr_valid (pr_valid),
        .pr_ready (pr_ready),
        .pr       (pr)
    );

    // two add stages
    bcs_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .pr_valid (pr_valid),
        .pr_ready (pr_ready),
        .pr       (pr),
        .sm_valid (sm_valid),
        .sm_ready (sm_ready),
        .sm       (sm)
    );

    // truncation and segment assembly, output register
    bcs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .sm_valid  (sm_valid),
        .sm_ready  (sm_ready),
        .sm        (sm),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

endmodule

>>> rtl/core/bcs_seq.sv
// sequencer: takes end points, issues one curve evaluation per cycle unless stalled
// depends on bcs_pkg; holds the per-step weight tables built at elaboration
module bcs_seq #(
    parameter int SEGMENTS = bcs_pkg::SEGMENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pts_valid,
    output logic          pts_ready,
    input  bcs_pkg::pts_t pts,
    output logic          ev_valid,
    input  logic          ev_ready,
    output bcs_pkg::eval_t ev
);
    import bcs_pkg::*;

    localparam int KW = $clog2(SEGMENTS + 1);

    // weights per step: g = T^2 (3 - 2t) and f = 3 T U (U - T), all scaled to 2^48
    logic        [GW-1:0] g_tab [0:SEGMENTS];
    logic signed [FW-1:0] f_tab [0:SEGMENTS];

    for (genvar i = 0; i <= SEGMENTS; i++) begin : g_weights
        localparam longint TK = (longint'(i) * 65536) / SEGMENTS;
        localparam longint UK = 65536 - TK;
        localparam longint GK = TK * TK * (3 * 65536 - 2 * TK);
        localparam longint FK = 3 * TK * UK * (UK - TK);
        assign g_tab[i] = GW'(GK);
        assign f_tab[i] = FW'(FK);
    end

    logic                 busy_reg, busy_next;
    logic [KW-1:0]        k_reg, k_next;
    logic signed [15:0]   sx_reg, sy_reg, hx_reg;
    logic signed [16:0]   dx_reg, dy_reg;
    logic                 ev_valid_reg, ev_valid_next;
    eval_t                ev_reg;

    logic                 ev_load;
    logic                 issue;
    logic                 at_last;
    logic                 accept;
    logic signed [16:0]   dx_in;
    logic signed [16:0]   dx_rnd;

    assign ev_load   = !ev_valid_reg || ev_ready;
    assign issue     = busy_reg && ev_load;
    assign at_last   = (k_reg == KW'(SEGMENTS));
    assign pts_ready = !busy_reg || (issue && at_last);
    assign accept    = pts_valid && pts_ready;

    // half the x span, truncated toward zero
    assign dx_in  = 17'(pts.end_x) - 17'(pts.start_x);
    assign dx_rnd = dx_in + {16'b0, dx_in[16]};

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (issue)
        begin
            k_next = k_reg + KW'(1);
            if (at_last)
                busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            k_next    = KW'(1);
        end
    end

    always_comb
    begin
        ev_valid_next = ev_load ? busy_reg : ev_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            k_reg        <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            k_reg        <= k_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= pts.start_x;
            sy_reg <= pts.start_y;
            dx_reg <= dx_in;
            hx_reg <= dx_rnd[16:1];
            dy_reg <= 17'(pts.end_y) - 17'(pts.start_y);
        end
        if (issue)
        begin
            ev_reg.sx    <= sx_reg;
            ev_reg.sy    <= sy_reg;
            ev_reg.dx    <= dx_reg;
            ev_reg.hx    <= hx_reg;
            ev_reg.dy    <= dy_reg;
            ev_reg.g     <= g_tab[k_reg];
            ev_reg.f     <= f_tab[k_reg];
            ev_reg.first <= (k_reg == KW'(1));
            ev_reg.last  <= at_last;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

>>> rtl/core/bcs_mul.sv
// multiply stage: span times weight, weights split in two halves
// depends on bcs_pkg
module bcs_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ev_valid,
    output logic            ev_ready,
    input  bcs_pkg::eval_t  ev,
    output logic            pr_valid,
    input  logic            pr_ready,
    output bcs_pkg::prod_t  pr
);
    import bcs_pkg::*;

    logic  pr_valid_reg, pr_valid_next;
    prod_t pr_reg;
    logic  load;

    assign load     = !pr_valid_reg || pr_ready;
    assign ev_ready = load;

    always_comb
    begin
        pr_valid_next = load ? ev_valid : pr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_valid_reg <= 1'b0;
        else
            pr_valid_reg <= pr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && ev_valid)
        begin
            pr_reg.sx    <= ev.sx;
            pr_reg.sy    <= ev.sy;
            pr_reg.xg_lo <= ev.dx * $signed({1'b0, ev.g[SPLIT-1:0]});
            pr_reg.xg_hi <= ev.dx * $signed({1'b0, ev.g[GW-1:SPLIT]});
            pr_reg.xf_lo <= ev.hx * $signed({1'b0, ev.f[SPLIT-1:0]});
            pr_reg.xf_hi <= ev.hx * $signed(ev.f[FW-1:SPLIT]);
            pr_reg.yg_lo <= ev.dy * $signed({1'b0, ev.g[SPLIT-1:0]});
            pr_reg.yg_hi <= ev.dy * $signed({1'b0, ev.g[GW-1:SPLIT]});
            pr_reg.first <= ev.first;
            pr_reg.last  <= ev.last;
        end
    end

    assign pr_valid = pr_valid_reg;
    assign pr       = pr_reg;

endmodule

>>> rtl/core/bcs_sum.sv
// two add stages: recombine partial products, then add the start point
// depends on bcs_pkg
module bcs_sum (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pr_valid,
    output logic           pr_ready,
    input  bcs_pkg::prod_t pr,
    output logic           sm_valid,
    input  logic           sm_ready,
    output bcs_pkg::sum_t  sm
);
    import bcs_pkg::*;

    logic  ac_valid_reg, ac_valid_next;
    logic  sm_valid_reg, sm_valid_next;
    acc_t  ac_reg;
    sum_t  sm_reg;
    logic  ac_load, sm_load;

    assign sm_load  = !sm_valid_reg || sm_ready;
    assign ac_load  = !ac_valid_reg || sm_load;
    assign pr_ready = ac_load;

    always_comb
    begin
        ac_valid_next = ac_load ? pr_valid : ac_valid_reg;
        sm_valid_next = sm_load ? ac_valid_reg : sm_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_valid_reg <= 1'b0;
            sm_valid_reg <= 1'b0;
        end
        else
        begin
            ac_valid_reg <= ac_valid_next;
            sm_valid_reg <= sm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ac_load && pr_valid)
        begin
            ac_reg.sx    <= pr.sx;
            ac_reg.sy    <= pr.sy;
            ac_reg.xg    <= (SW'(pr.xg_hi) <<< SPLIT) + SW'(pr.xg_lo);
            ac_reg.xf    <= (SW'(pr.xf_hi) <<< SPLIT) + SW'(pr.xf_lo);
            ac_reg.yg    <= (SW'(pr.yg_hi) <<< SPLIT) + SW'(pr.yg_lo);
            ac_reg.first <= pr.first;
            ac_reg.last  <= pr.last;
        end
        if (sm_load && ac_valid_reg)
        begin
            sm_reg.sx    <= ac_reg.sx;
            sm_reg.sy    <= ac_reg.sy;
            sm_reg.px    <= (SW'(ac_reg.sx) <<< FRAC) + ac_reg.xg + ac_reg.xf;
            sm_reg.py    <= (SW'(ac_reg.sy) <<< FRAC) + ac_reg.yg;
            sm_reg.first <= ac_reg.first;
            sm_reg.last  <= ac_reg.last;
        end
    end

    assign sm_valid = sm_valid_reg;
    assign sm       = sm_reg;

endmodule

>>> rtl/core/bcs_out.sv
// output stage: truncate sums toward zero, pair with the previous point
// depends on bcs_pkg
module bcs_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sm_valid,
    output logic          sm_ready,
    input  bcs_pkg::sum_t sm,
    output logic          seg_valid,
    input  logic          seg_ready,
    output bcs_pkg::seg_t seg
);
    import bcs_pkg::*;

    logic               seg_valid_reg, seg_valid_next;
    seg_t               seg_reg;
    logic               load;
    logic signed [15:0] qx, qy;

    assign load     = !seg_valid_reg || seg_ready;
    assign sm_ready = load;

    // floor, then step up by one for a negative value with a fraction
    assign qx = sm.px[FRAC+15:FRAC] + 16'(sm.px[SW-1] && (|sm.px[FRAC-1:0]));
    assign qy = sm.py[FRAC+15:FRAC] + 16'(sm.py[SW-1] && (|sm.py[FRAC-1:0]));

    always_comb
    begin
        seg_valid_next = load ? sm_valid : seg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_valid_reg <= 1'b0;
        else
            seg_valid_reg <= seg_valid_next;
    end

    // the register still holds the previous beat's end point
    always_ff @(posedge clk)
    begin
        if (load && sm_valid)
        begin
            seg_reg.seg_x0       <= sm.first ? sm.sx : seg_reg.seg_x1;
            seg_reg.seg_y0       <= sm.first ? sm.sy : seg_reg.seg_y1;
            seg_reg.seg_x1       <= qx;
            seg_reg.seg_y1       <= qy;
            seg_reg.last_segment <= sm.last;
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

endmodule

>>> rtl/core/bcs_check.sv
// port-level checks for the bezier connector segmenter, bound to the top
// depends on bcs_pkg and bezier_connector_segments
module bcs_check #(
    parameter int SEGMENTS = bcs_pkg::SEGMENTS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          pts_valid,
    input logic          pts_ready,
    input logic          seg_valid,
    input logic          seg_ready,
    input bcs_pkg::seg_t seg
);
    import bcs_pkg::*;

    localparam int CW = $clog2(SEGMENTS);

    logic               pts_beat, seg_beat;
    logic [CW-1:0]      run_reg, run_next;
    logic               cont_reg, cont_next;
    logic signed [15:0] px_reg, py_reg;
    logic [3:0]         open_reg, open_next;

    assign pts_beat = pts_valid && pts_ready;
    assign seg_beat = seg_valid && seg_ready;

    always_comb
    begin
        run_next  = run_reg;
        cont_next = cont_reg;
        open_next = open_reg + 4'(pts_beat) - 4'(seg_beat && seg.last_segment);
        if (seg_beat)
        begin
            run_next  = seg.last_segment ? '0 : run_reg + CW'(1);
            cont_next = !seg.last_segment;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            cont_reg <= 1'b0;
            open_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            cont_reg <= cont_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_beat)
        begin
            px_reg <= seg.seg_x1;
            py_reg <= seg.seg_y1;
        end
    end

    // a stalled result holds
    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid && $stable(seg))
        else $error("seg beat changed while stalled");

    // segments within a run are joined end to start
    a_joined: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && cont_reg |-> seg.seg_x0 == px_reg && seg.seg_y0 == py_reg)
        else $error("segment does not start where the previous one ended");

    // the run ends on exactly the last segment
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> seg.last_segment == (run_reg == CW'(SEGMENTS - 1)))
        else $error("last_segment out of place");

    // no segment without a connector in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> open_reg != 4'd0)
        else $error("segment beat with no connector accepted");

endmodule

bind bezier_connector_segments bcs_check #(
    .SEGMENTS (SEGMENTS)
) u_bcs_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .pts_valid (pts_valid),
    .pts_ready (pts_ready),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
);
